### rtl/core/protobuf_scalar_field_encoder_macros.svh
// assertion macros for the protobuf scalar field encoder
`ifndef PROTOBUF_SCALAR_FIELD_ENCODER_MACROS_SVH
`define PROTOBUF_SCALAR_FIELD_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PBSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbse assertion failed");

// next-cycle implication, disabled during reset
`define PBSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbse assertion failed");

`endif

### rtl/core/pbse_pkg.sv
// types, kind codes and helpers shared by the field encoder modules
package pbse_pkg;

  typedef enum logic [3:0] {
    KIND_VARINT32 = 4'd0,
    KIND_VARINT64 = 4'd1,
    KIND_ZIGZAG32 = 4'd2,
    KIND_ZIGZAG64 = 4'd3,
    KIND_FIXED32  = 4'd4,
    KIND_FIXED64  = 4'd5,
    KIND_BOOL     = 4'd6,
    KIND_FLOAT32  = 4'd7,
    KIND_FLOAT64  = 4'd8
  } kind_t;

  // one classified field waiting for serialization
  typedef struct packed {
    logic [31:0] tag;
    logic [2:0]  tag_len;
    logic [63:0] val;
    logic [3:0]  val_len;
    logic        fixed;
  } entry_t;

  // number of 7-bit groups needed to carry v as a varint
  function automatic logic [3:0] varint_len(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if ((v >> (7 * i)) != 64'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

### rtl/core/protobuf_scalar_field_encoder.sv
// Scalar protobuf field encoder: each input transfer carries one field (tag, kind, value,
// skip-if-zero flag); the block emits the tag as a base-128 varint followed by the value as a
// varint, zigzag varint, little-endian fixed32/fixed64 word or bool byte, one byte per output
// transfer with tlast on the final byte. A field yields 2 to 15 bytes and occupies the output
// serializer until its last byte is sent, one byte per cycle while out_tready does not stall it.
// Fields that are skipped as zero or carry an unknown kind are taken and produce nothing. The
// front end classifies a field in the cycle it is taken and parks it in a queue of QUEUE_DEPTH
// entries, so input keeps flowing while the serializer drains earlier fields; output
// backpressure holds the serializer.
module protobuf_scalar_field_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // field_tag[31:0], field_value[95:32]
  input  logic [4:0]  in_tuser,   // kind[3:0], skip_if_zero[4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast
);

  logic             keep;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  pbse_pkg::entry_t front_entry;
  pbse_pkg::entry_t q_data;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && keep;

  pbse_front u_front (
    .field_tag    (in_tdata[31:0]),
    .kind         (in_tuser[3:0]),
    .field_value  (in_tdata[95:32]),
    .skip_if_zero (in_tuser[4]),
    .keep         (keep),
    .entry        (front_entry)
  );

  pbse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  pbse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/core/pbse_front.sv
// front end: zero test, zigzag mapping and byte counts for one field
module pbse_front (
  input  logic [31:0]     field_tag,
  input  logic [3:0]      kind,
  input  logic [63:0]     field_value,
  input  logic            skip_if_zero,
  output logic            keep,
  output pbse_pkg::entry_t entry
);

  logic [31:0] lo;
  logic        is_zero;
  logic        known;
  logic [31:0] zz32;
  logic [63:0] zz64;

  assign lo   = field_value[31:0];
  assign zz32 = {lo[30:0], 1'b0} ^ {32{lo[31]}};
  assign zz64 = {field_value[62:0], 1'b0} ^ {64{field_value[63]}};

  always_comb begin
    known         = 1'b1;
    is_zero       = (field_value == 64'd0);
    entry.tag     = field_tag;
    entry.tag_len = 3'(pbse_pkg::varint_len({32'd0, field_tag}));
    entry.val     = field_value;
    entry.val_len = 4'd1;
    entry.fixed   = 1'b0;
    unique case (kind)
      pbse_pkg::KIND_VARINT32: begin
        is_zero       = (lo == 32'd0);
        entry.val     = {32'd0, lo};
        entry.val_len = pbse_pkg::varint_len({32'd0, lo});
      end
      pbse_pkg::KIND_VARINT64: begin
        entry.val_len = pbse_pkg::varint_len(field_value);
      end
      pbse_pkg::KIND_ZIGZAG32: begin
        is_zero       = (lo == 32'd0);
        entry.val     = {32'd0, zz32};
        entry.val_len = pbse_pkg::varint_len({32'd0, zz32});
      end
      pbse_pkg::KIND_ZIGZAG64: begin
        entry.val     = zz64;
        entry.val_len = pbse_pkg::varint_len(zz64);
      end
      pbse_pkg::KIND_FIXED32, pbse_pkg::KIND_FLOAT32: begin
        is_zero       = (kind == pbse_pkg::KIND_FLOAT32) ? (lo[30:0] == 31'd0)
                                                         : (lo == 32'd0);
        entry.val     = {32'd0, lo};
        entry.val_len = 4'd4;
        entry.fixed   = 1'b1;
      end
      pbse_pkg::KIND_FIXED64, pbse_pkg::KIND_FLOAT64: begin
        is_zero       = (kind == pbse_pkg::KIND_FLOAT64) ? (field_value[62:0] == 63'd0)
                                                         : (field_value == 64'd0);
        entry.val_len = 4'd8;
        entry.fixed   = 1'b1;
      end
      pbse_pkg::KIND_BOOL: begin
        entry.val     = {63'd0, (field_value != 64'd0)};
        entry.val_len = 4'd1;
        entry.fixed   = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    keep = known && !(skip_if_zero && is_zero);
  end

endmodule

### rtl/core/pbse_fifo.sv
// short queue of classified fields between front and back end
module pbse_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pbse_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output pbse_pkg::entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pbse_pkg::entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

### rtl/core/pbse_back.sv
// back end: serializes tag and value into the output register, one byte per cycle unless stalled
`include "protobuf_scalar_field_encoder_macros.svh"

module pbse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  pbse_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  logic        busy_r, busy_nxt;
  logic        tag_phase_r, tag_phase_nxt;
  logic [31:0] tag_sh_r, tag_sh_nxt;
  logic [2:0]  tag_cnt_r, tag_cnt_nxt;
  logic [63:0] val_sh_r, val_sh_nxt;
  logic [3:0]  val_cnt_r, val_cnt_nxt;
  logic        fixed_r, fixed_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic       emit;
  logic       emit_last;
  logic [7:0] cur_byte;

  assign emit      = busy_r && (!out_valid_r || out_tready);
  assign emit_last = !tag_phase_r && (val_cnt_r == 4'd1);
  assign q_pop     = q_valid && (!busy_r || (emit && emit_last));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    if (tag_phase_r) begin
      cur_byte = {(tag_cnt_r != 3'd1), tag_sh_r[6:0]};
    end else if (fixed_r) begin
      cur_byte = val_sh_r[7:0];
    end else begin
      cur_byte = {(val_cnt_r != 4'd1), val_sh_r[6:0]};
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    tag_phase_nxt = tag_phase_r;
    tag_sh_nxt    = tag_sh_r;
    tag_cnt_nxt   = tag_cnt_r;
    val_sh_nxt    = val_sh_r;
    val_cnt_nxt   = val_cnt_r;
    fixed_nxt     = fixed_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = emit_last;
      if (tag_phase_r) begin
        tag_sh_nxt  = tag_sh_r >> 7;
        tag_cnt_nxt = tag_cnt_r - 3'd1;
        if (tag_cnt_r == 3'd1) tag_phase_nxt = 1'b0;
      end else begin
        val_sh_nxt  = fixed_r ? (val_sh_r >> 8) : (val_sh_r >> 7);
        val_cnt_nxt = val_cnt_r - 4'd1;
        if (emit_last) busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt      = 1'b1;
      tag_phase_nxt = 1'b1;
      tag_sh_nxt    = q_data.tag;
      tag_cnt_nxt   = q_data.tag_len;
      val_sh_nxt    = q_data.val;
      val_cnt_nxt   = q_data.val_len;
      fixed_nxt     = q_data.fixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      tag_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      tag_phase_r <= tag_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_sh_r   <= tag_sh_nxt;
    tag_cnt_r  <= tag_cnt_nxt;
    val_sh_r   <= val_sh_nxt;
    val_cnt_r  <= val_cnt_nxt;
    fixed_r    <= fixed_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // counters never run out inside their own phase
  `PBSE_ASSERT_IMPL(a_tag_cnt, clk, rst_n, busy_r && tag_phase_r, tag_cnt_r != 3'd0)
  `PBSE_ASSERT_IMPL(a_val_cnt, clk, rst_n, busy_r, val_cnt_r != 4'd0)
  // a new field is taken only when the current one is done or finishing
  `PBSE_ASSERT_IMPL(a_pop_safe, clk, rst_n, q_pop && busy_r, emit && emit_last)
  // every emitted byte shows up as a valid output next cycle
  `PBSE_ASSERT_NEXT(a_emit_out, clk, rst_n, emit, out_valid_r)

endmodule
